// ----- rtl/core/sdrc_pkg.sv -----
// sdrc_pkg: shared types and constants of the stereo dynamic range compressor
// fixed-point scale factors, register indexes and the 2^(2^-k) root table
// no dependencies
`timescale 1ns / 1ps

package sdrc_pkg;

    localparam int MUL_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int MAX_LTB   = 12;

    localparam logic [31:0] DB_PER_OCT = 32'd394566;
    localparam logic [31:0] OCT_PER_DB = 32'd10885;
    localparam logic [31:0] KNEE_SCALE = 32'd136406;
    localparam logic [15:0] UP_CLAMP   = 16'd15360;
    localparam logic signed [15:0] UP_FLOOR = -16'sd25600;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_SLOPE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_COEFS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THRESH  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UP_SLOPE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UP_COEFS   = 4'd7;

    typedef logic [31:0] root_tab_t [0:MAX_LTB];

    // c(0) = 2.0, c(k) = floor(sqrt(c(k-1) * 2^30)), unsigned Q2.30
    function automatic root_tab_t root_table();
        root_tab_t  tab;
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        tab[0] = 32'h8000_0000;
        c = 64'h8000_0000;
        for (int k = 1; k <= MAX_LTB; k++)
        begin
            x = c << 30;
            r = '0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t POW2_ROOT = root_table();

endpackage

// ----- rtl/core/stereo_dynamic_range_compressor.sv -----
// stereo_dynamic_range_compressor: peak compressor with optional upward branch
// sequencer around one shared multiplier (sdrc_mul); constants from sdrc_pkg
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_ready) takes one word: a stereo frame and a
// stereo key frame. The output channel (out_valid/out_ready) returns one
// processed stereo word per input word, in order.
// Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; write them only while the block is idle.
// Timing: every multiplication of the work runs through the one 32x32 multiplier,
// whose product is registered. A silent key skips the sixteen log squarings;
// the exponent runs once, or twice when the upward branch is enabled.
// in_ready is high only between words.
// Stall: the result waits in the output register; the next word is accepted
// and processed meanwhile, and only its final hand-over waits for the
// register to free.
// Reset: configuration registers take their defaults, both envelopes clear,
// out_valid drops and the block is ready at once.

module stereo_dynamic_range_compressor
    import sdrc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int LOG_TABLE_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    input  logic signed [SAMPLE_BITS-1:0] key_left,
    input  logic signed [SAMPLE_BITS-1:0] key_right,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int LTB = LOG_TABLE_BITS;
    localparam int EW  = $clog2(SB);
    localparam logic [EW-1:0] SB_M1  = EW'(SB - 1);
    localparam logic [30:0]   M_KEEP = ~31'((32'd1 << (30 - LTB)) - 32'd1);
    localparam logic [48:0]   LIM_POS = 49'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [48:0]   LIM_NEG = 49'(64'd1 << (SB - 1));

    typedef enum logic [27:0] {
        S_IDLE  = 28'h0000001,
        S_NORM  = 28'h0000002,
        S_SQ    = 28'h0000004,
        S_SQW   = 28'h0000008,
        S_DB    = 28'h0000010,
        S_DBW   = 28'h0000020,
        S_OV    = 28'h0000040,
        S_OVW   = 28'h0000080,
        S_FOL   = 28'h0000100,
        S_FOLW  = 28'h0000200,
        S_GR    = 28'h0000400,
        S_GRW   = 28'h0000800,
        S_AV    = 28'h0001000,
        S_AVW   = 28'h0002000,
        S_EXP   = 28'h0004000,
        S_EXPW  = 28'h0008000,
        S_EXPSH = 28'h0010000,
        S_UN    = 28'h0020000,
        S_UNW   = 28'h0040000,
        S_G1    = 28'h0080000,
        S_G2    = 28'h0100000,
        S_G3    = 28'h0200000,
        S_GW    = 28'h0400000,
        S_GWW   = 28'h0800000,
        S_MX1   = 28'h1000000,
        S_MX2   = 28'h2000000,
        S_MX3   = 28'h4000000,
        S_DONE  = 28'h8000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [14:0] thr_reg;
    logic [15:0] down_slope_reg;
    logic [31:0] down_coefs_reg;
    logic [19:0] wet_gain_reg;
    logic [16:0] dry_gain_reg;
    logic [15:0] uthr_reg;
    logic [15:0] up_slope_reg;
    logic [31:0] up_coefs_reg;

    // control
    logic [3:0]  cnt_reg;
    logic        up_phase_reg;
    logic        lane_reg;
    logic        out_valid_reg;
    logic [15:0] env_down_reg;
    logic [15:0] env_up_reg;

    // datapath
    logic [SB-1:0]      magl_reg, magr_reg, peak_reg;
    logic               negl_reg, negr_reg;
    logic [EW-1:0]      e_reg;
    logic [30:0]        m_reg;
    logic [15:0]        frac_reg;
    logic [15:0]        pdbn_reg;
    logic signed [18:0] dd_reg;
    logic [15:0]        tgt_reg;
    logic               dir_reg;
    logic [15:0]        gr_reg;
    logic signed [6:0]  n_reg;
    logic [LTB-1:0]     fsh_reg;
    logic [30:0]        em_reg;
    logic [17:0]        gv_reg;
    logic [50:0]        boost_reg;
    logic [18:0]        lo_reg;
    logic [31:0]        g16_reg;
    logic [31:0]        gw_reg;
    logic [63:0]        acc_reg;
    logic [SB-1:0]      res_l_reg, res_r_reg;
    logic [SB-1:0]      out_left_reg, out_right_reg;

    // multiplier
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;

    // combinational helpers
    logic [SB-1:0]      in_magl, in_magr, key_magl, key_magr;
    logic [EW-1:0]      lead;
    logic [63:0]        norm64;
    logic [31:0]        sq_t;
    logic [EW+15:0]     oct_mag, mag_db;
    logic [EW-1:0]      oct_int;
    logic [15:0]        pdbn_w;
    logic signed [18:0] dd_w;
    logic [47:0]        ov_w;
    logic [15:0]        env_sel, slope_sel;
    logic [31:0]        coefs_sel;
    logic               dir_w;
    logic [15:0]        dlt_w, coef_w, rnd_w, env_new;
    logic [21:0]        av_w;
    logic signed [22:0] xs_w;
    logic [4:0]         shl_w;
    logic [6:0]         shr_w;
    logic [50:0]        expv_w;
    logic               up_en;
    logic signed [18:0] uu_w;
    logic [SB-1:0]      mag_lane;
    logic               neg_lane;
    logic [64:0]        sum65;
    logic [48:0]        v_w, sat_w;
    logic [SB-1:0]      res_w;
    logic               out_free;

    sdrc_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_magl  = in_left[SB-1]   ? SB'(-in_left)   : in_left;
    assign in_magr  = in_right[SB-1]  ? SB'(-in_right)  : in_right;
    assign key_magl = key_left[SB-1]  ? SB'(-key_left)  : key_left;
    assign key_magr = key_right[SB-1] ? SB'(-key_right) : key_right;

    // leading one of the key peak
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < SB; i++)
        begin
            if (peak_reg[i])
            begin
                lead = EW'(i);
            end
        end
    end

    assign norm64  = (64'(peak_reg) << 30) >> lead;
    assign sq_t    = prod[61:30];
    assign oct_int = SB_M1 - e_reg;
    assign oct_mag = {oct_int, 16'h0000};
    assign mag_db  = (oct_mag >= (EW+16)'(frac_reg)) ? oct_mag - (EW+16)'(frac_reg) : '0;
    assign pdbn_w  = 16'((prod + 64'd8388608) >> 24);
    assign dd_w    = -$signed({3'b000, pdbn_w}) - $signed({{4{thr_reg[14]}}, thr_reg});
    assign ov_w    = 48'((prod + 64'd32768) >> 16);

    assign env_sel   = up_phase_reg ? env_up_reg : env_down_reg;
    assign coefs_sel = up_phase_reg ? up_coefs_reg : down_coefs_reg;
    assign slope_sel = up_phase_reg ? up_slope_reg : down_slope_reg;
    assign dir_w     = tgt_reg > env_sel;
    assign dlt_w     = dir_w ? tgt_reg - env_sel : env_sel - tgt_reg;
    assign coef_w    = dir_w ? coefs_sel[31:16] : coefs_sel[15:0];
    assign rnd_w     = 16'((prod + 64'd32768) >> 16);
    assign env_new   = dir_reg ? tgt_reg - rnd_w : tgt_reg + rnd_w;

    assign av_w = 22'((prod + 64'd128) >> 8);
    assign xs_w = up_phase_reg ? $signed({1'b0, av_w}) : -$signed({1'b0, av_w});

    assign shl_w = (n_reg > 7'sd20) ? 5'd20 : n_reg[4:0];
    assign shr_w = 7'(-n_reg);
    assign expv_w = n_reg[6] ? 51'(em_reg >> shr_w) : (51'(em_reg) << shl_w);

    assign up_en = (up_slope_reg != 16'd0) && ($signed(uthr_reg) > UP_FLOOR)
                   && (peak_reg != '0);
    assign uu_w  = $signed({{3{uthr_reg[15]}}, uthr_reg}) + $signed({3'b000, pdbn_reg});

    assign mag_lane = lane_reg ? magr_reg : magl_reg;
    assign neg_lane = lane_reg ? negr_reg : negl_reg;
    assign sum65    = {1'b0, acc_reg} + {1'b0, prod} + 65'd32768;
    assign v_w      = sum65[64:16];
    always_comb
    begin
        if (neg_lane)
        begin
            sat_w = (v_w > LIM_NEG) ? LIM_NEG : v_w;
            res_w = SB'(-sat_w);
        end
        else
        begin
            sat_w = (v_w > LIM_POS) ? LIM_POS : v_w;
            res_w = SB'(sat_w);
        end
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
            end
            S_DB:
            begin
                mul_a = 32'(mag_db);
                mul_b = DB_PER_OCT;
            end
            S_OV:
            begin
                mul_a = 32'($unsigned(dd_reg));
                mul_b = KNEE_SCALE;
            end
            S_FOL:
            begin
                mul_a = 32'(coef_w);
                mul_b = 32'(dlt_w);
            end
            S_GR:
            begin
                mul_a = 32'(env_sel);
                mul_b = 32'(slope_sel);
            end
            S_AV:
            begin
                mul_a = 32'(gr_reg);
                mul_b = OCT_PER_DB;
            end
            S_EXP:
            begin
                mul_a = 32'(em_reg);
                mul_b = POW2_ROOT[cnt_reg + 4'd1];
            end
            S_UN:
            begin
                mul_a = 32'($unsigned(uu_w));
                mul_b = KNEE_SCALE;
            end
            S_G1:
            begin
                mul_a = 32'(gv_reg);
                mul_b = 32'(boost_reg[29:0]);
            end
            S_G2:
            begin
                mul_a = 32'(gv_reg);
                mul_b = 32'(boost_reg[50:30]);
            end
            S_GW:
            begin
                mul_a = g16_reg;
                mul_b = 32'(wet_gain_reg);
            end
            S_MX1:
            begin
                mul_a = 32'(mag_lane);
                mul_b = gw_reg;
            end
            S_MX2:
            begin
                mul_a = 32'(mag_lane);
                mul_b = 32'(dry_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = in_valid ? S_NORM : S_IDLE;
            S_NORM:  state_next = (peak_reg == '0) ? S_FOL : S_SQ;
            S_SQ:    state_next = S_SQW;
            S_SQW:   state_next = (cnt_reg == 4'd15) ? S_DB : S_SQ;
            S_DB:    state_next = S_DBW;
            S_DBW:   state_next = (dd_w > 19'sd0) ? S_OV : S_FOL;
            S_OV:    state_next = S_OVW;
            S_OVW:   state_next = S_FOL;
            S_FOL:   state_next = S_FOLW;
            S_FOLW:  state_next = S_GR;
            S_GR:    state_next = S_GRW;
            S_GRW:   state_next = S_AV;
            S_AV:    state_next = S_AVW;
            S_AVW:   state_next = S_EXP;
            S_EXP:   state_next = S_EXPW;
            S_EXPW:  state_next = (cnt_reg == 4'(LTB - 1)) ? S_EXPSH : S_EXP;
            S_EXPSH: state_next = (!up_phase_reg && up_en) ? S_UN : S_G1;
            S_UN:    state_next = (uu_w > 19'sd0) ? S_UNW : S_FOL;
            S_UNW:   state_next = S_FOL;
            S_G1:    state_next = S_G2;
            S_G2:    state_next = S_G3;
            S_G3:    state_next = S_GW;
            S_GW:    state_next = S_GWW;
            S_GWW:   state_next = S_MX1;
            S_MX1:   state_next = S_MX2;
            S_MX2:   state_next = S_MX3;
            S_MX3:   state_next = lane_reg ? S_DONE : S_MX1;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // control, configuration and envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            up_phase_reg   <= 1'b0;
            lane_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            env_down_reg   <= '0;
            env_up_reg     <= '0;
            thr_reg        <= '0;
            down_slope_reg <= 16'd49152;
            down_coefs_reg <= '0;
            wet_gain_reg   <= 20'd65536;
            dry_gain_reg   <= '0;
            uthr_reg       <= 16'(UP_FLOOR);
            up_slope_reg   <= '0;
            up_coefs_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            case (state_reg)
                S_NORM:  cnt_reg <= '0;
                S_SQW:   cnt_reg <= cnt_reg + 4'd1;
                S_AVW:   cnt_reg <= '0;
                S_EXPW:  cnt_reg <= cnt_reg + 4'd1;
                default: cnt_reg <= cnt_reg;
            endcase

            if (state_reg == S_NORM)
            begin
                up_phase_reg <= 1'b0;
            end
            else if (state_reg == S_EXPSH && !up_phase_reg && up_en)
            begin
                up_phase_reg <= 1'b1;
            end

            if (state_reg == S_GWW)
            begin
                lane_reg <= 1'b0;
            end
            else if (state_reg == S_MX3)
            begin
                lane_reg <= 1'b1;
            end

            if (state_reg == S_FOLW)
            begin
                if (up_phase_reg)
                begin
                    env_up_reg <= env_new;
                end
                else
                begin
                    env_down_reg <= env_new;
                end
            end

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  thr_reg        <= cfg_data[14:0];
                    REG_DOWN_SLOPE: down_slope_reg <= cfg_data[15:0];
                    REG_DOWN_COEFS: down_coefs_reg <= cfg_data;
                    REG_WET_GAIN:   wet_gain_reg   <= cfg_data[19:0];
                    REG_DRY_GAIN:   dry_gain_reg   <= cfg_data[16:0];
                    REG_UP_THRESH:  uthr_reg       <= cfg_data[15:0];
                    REG_UP_SLOPE:   up_slope_reg   <= cfg_data[15:0];
                    REG_UP_COEFS:   up_coefs_reg   <= cfg_data;
                    default:        thr_reg        <= thr_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                magl_reg <= in_magl;
                magr_reg <= in_magr;
                negl_reg <= in_left[SB-1];
                negr_reg <= in_right[SB-1];
                peak_reg <= (key_magl > key_magr) ? key_magl : key_magr;
            end
            S_NORM:
            begin
                e_reg    <= lead;
                m_reg    <= norm64[30:0] & M_KEEP;
                frac_reg <= '0;
                pdbn_reg <= '0;
                tgt_reg  <= '0;
            end
            S_SQW:
            begin
                frac_reg <= {frac_reg[14:0], sq_t[31]};
                m_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
            end
            S_DBW:
            begin
                pdbn_reg <= pdbn_w;
                dd_reg   <= dd_w;
                tgt_reg  <= '0;
            end
            S_OVW:
            begin
                tgt_reg <= (ov_w > 48'd65535) ? 16'hFFFF : ov_w[15:0];
            end
            S_FOL:
            begin
                dir_reg <= dir_w;
            end
            S_GRW:
            begin
                gr_reg <= rnd_w;
            end
            S_AVW:
            begin
                n_reg   <= xs_w[22:16];
                fsh_reg <= xs_w[15:16-LTB];
                em_reg  <= ONE_Q30;
            end
            S_EXPW:
            begin
                if (fsh_reg[LTB-1])
                begin
                    em_reg <= 31'((prod + 64'd536870912) >> 30);
                end
                fsh_reg <= fsh_reg << 1;
            end
            S_EXPSH:
            begin
                if (up_phase_reg)
                begin
                    boost_reg <= expv_w;
                end
                else
                begin
                    gv_reg    <= 18'((expv_w + 51'd8192) >> 14);
                    boost_reg <= 51'(ONE_Q30);
                end
            end
            S_UN:
            begin
                tgt_reg <= '0;
            end
            S_UNW:
            begin
                tgt_reg <= (ov_w > 48'(UP_CLAMP)) ? UP_CLAMP : ov_w[15:0];
            end
            S_G2:
            begin
                lo_reg <= 19'((prod + 64'd536870912) >> 30);
            end
            S_G3:
            begin
                g16_reg <= prod[31:0] + 32'(lo_reg);
            end
            S_GWW:
            begin
                gw_reg <= 32'((prod + 64'd32768) >> 16);
            end
            S_MX2:
            begin
                acc_reg <= prod;
            end
            S_MX3:
            begin
                if (lane_reg)
                begin
                    res_r_reg <= res_w;
                end
                else
                begin
                    res_l_reg <= res_w;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_left_reg  <= res_l_reg;
                    out_right_reg <= res_r_reg;
                end
            end
            default:
            begin
                dir_reg <= dir_reg;
            end
        endcase
    end

endmodule

// ----- rtl/core/sdrc_mul.sv -----
// sdrc_mul: shared unsigned multiplier with a registered product
// depends on sdrc_pkg for the operand width
`timescale 1ns / 1ps

module sdrc_mul
    import sdrc_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   prod
);

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/sdrc_check.sv -----
// sdrc_check: port-level assertions for the compressor
// bound to stereo_dynamic_range_compressor; no package needed
`timescale 1ns / 1ps

module sdrc_check
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [SAMPLE_BITS-1:0] in_left,
    input logic [SAMPLE_BITS-1:0] in_right,
    input logic [SAMPLE_BITS-1:0] key_left,
    input logic [SAMPLE_BITS-1:0] key_right,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_left,
    input logic [SAMPLE_BITS-1:0] out_right,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [3:0]             cfg_index,
    input logic [31:0]            cfg_data
);

    // block is busy right after taking a word
    busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    // a new result only appears as a word finishes
    result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a word in progress");

    // a stalled result holds
    stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
        else $error("result changed while stalled");

endmodule

bind stereo_dynamic_range_compressor sdrc_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (.*);

// ----- tb/tb_stereo_dynamic_range_compressor.sv -----
// tb_stereo_dynamic_range_compressor: self-checking bench for the stereo compressor
// bit-true gain predictor in a small scoreboard class; directed and random stimulus, idling and output stalls
// depends on sdrc_pkg and stereo_dynamic_range_compressor
`timescale 1ns / 1ps

class comp_scoreboard;
    logic [14:0] threshold_db;
    logic [15:0] down_slope;
    logic [31:0] down_coefs;
    logic [19:0] wet_gain;
    logic [16:0] dry_gain;
    logic [15:0] up_threshold_db;
    logic [15:0] up_slope;
    logic [31:0] up_coefs;
    logic [15:0] down_env;
    logic [15:0] up_env;
    logic [23:0] want_left[$];
    logic [23:0] want_right[$];
    int          fails;

    function void clear();
        threshold_db = 0; down_slope = 49152; down_coefs = 0; wet_gain = 65536;
        dry_gain = 0; up_threshold_db = 16'h9C00; up_slope = 0; up_coefs = 0;
        down_env = 0; up_env = 0; fails = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] d);
        case (idx)
            sdrc_pkg::REG_THRESHOLD:  threshold_db = d[14:0];
            sdrc_pkg::REG_DOWN_SLOPE: down_slope = d[15:0];
            sdrc_pkg::REG_DOWN_COEFS: down_coefs = d;
            sdrc_pkg::REG_WET_GAIN:   wet_gain = d[19:0];
            sdrc_pkg::REG_DRY_GAIN:   dry_gain = d[16:0];
            sdrc_pkg::REG_UP_THRESH:  up_threshold_db = d[15:0];
            sdrc_pkg::REG_UP_SLOPE:   up_slope = d[15:0];
            sdrc_pkg::REG_UP_COEFS:   up_coefs = d;
            default: ;
        endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function longint unsigned exp2_q30(longint a);
        longint          n;
        longint unsigned f, m, c, u, q, fi;
        if (a >= 0)
        begin
            n = a >>> 16;
            f = a & 64'hFFFF;
        end
        else
        begin
            u = -a;
            q = (u + 65535) >> 16;
            n = -q;
            f = q * 65536 - u;
        end
        fi = f >> 8;
        m = 64'd1 << 30;
        c = 64'd1 << 31;
        for (int k = 1; k <= 8; k++)
        begin
            c = int_sqrt(c << 30);
            if ((fi >> (8 - k)) & 1)
                m = (m * c + (64'd1 << 29)) >> 30;
        end
        if (n >= 0)
        begin
            if (n > 20) n = 20;
            return m << n;
        end
        if (-n >= 63) return 0;
        return m >> (-n);
    endfunction

    function longint unsigned peak_atten_db(longint unsigned p);
        int              e;
        longint unsigned m, frac, mag;
        e = 0;
        frac = 0;
        while (e < 63 && (p >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (p << (30 - e)) : (p >> (e - 30));
        m &= ~((64'd1 << 22) - 1);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31))
            begin
                frac |= 1;
                m >>= 1;
            end
        end
        mag = longint'(23 - e) << 16;
        mag = (mag >= frac) ? mag - frac : 0;
        return (mag * 394566 + (64'd1 << 23)) >> 24;
    endfunction

    function longint unsigned knee(longint d);
        if (d <= 0) return 0;
        return (d * 136406 + 32768) >> 16;
    endfunction

    function logic [15:0] smooth(logic [15:0] env, longint unsigned tgt, logic [31:0] cf);
        longint unsigned d;
        if (tgt > env)
        begin
            d = tgt - env;
            return tgt - ((cf[31:16] * d + 32768) >> 16);
        end
        d = env - tgt;
        return tgt + ((cf[15:0] * d + 32768) >> 16);
    endfunction

    function logic [23:0] apply(logic signed [23:0] x, longint unsigned g);
        longint unsigned mag, v, lim;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        v = (mag * g + mag * dry_gain + 32768) >> 16;
        lim = (x < 0) ? 64'd8388608 : 64'd8388607;
        if (v > lim) v = lim;
        return (x < 0) ? -v : v;
    endfunction

    function void note_frame(logic signed [23:0] il, ir, kl, kr);
        longint unsigned al, ar, peak, over, gr, a, gv, boost, under, b, g16, gw;
        longint          pdb, thr, uthr;
        al = (kl < 0) ? -longint'(kl) : longint'(kl);
        ar = (kr < 0) ? -longint'(kr) : longint'(kr);
        peak = (al > ar) ? al : ar;
        thr = $signed(threshold_db);
        uthr = $signed(up_threshold_db);
        pdb = 0;
        over = 0;
        boost = 64'd1 << 30;
        if (peak != 0)
        begin
            pdb = -longint'(peak_atten_db(peak));
            over = knee(pdb - thr);
            if (over > 65535) over = 65535;
        end
        down_env = smooth(down_env, over, down_coefs);
        gr = (down_env * longint'(down_slope) + 32768) >> 16;
        a = (gr * 10885 + 128) >> 8;
        gv = (exp2_q30(-longint'(a)) + 8192) >> 14;
        if (up_slope != 0 && uthr > -25600 && peak != 0)
        begin
            under = knee(uthr - pdb);
            if (under > 15360) under = 15360;
            up_env = smooth(up_env, under, up_coefs);
            b = (up_env * longint'(up_slope) + 32768) >> 16;
            b = (b * 10885 + 128) >> 8;
            boost = exp2_q30(b);
        end
        g16 = (gv * boost + (64'd1 << 29)) >> 30;
        gw = (g16 * wet_gain + 32768) >> 16;
        want_left.push_back(apply(il, gw));
        want_right.push_back(apply(ir, gw));
    endfunction

    function void check_frame(logic [23:0] ol, logic [23:0] orr);
        logic [23:0] el, er;
        if (want_left.size() == 0)
        begin
            $error("unexpected output word out_left=%h out_right=%h", ol, orr);
            fails++;
            return;
        end
        el = want_left.pop_front();
        er = want_right.pop_front();
        if (ol !== el)
        begin
            $error("out_left expected %h actual %h", el, ol);
            fails++;
        end
        if (orr !== er)
        begin
            $error("out_right expected %h actual %h", er, orr);
            fails++;
        end
    endfunction
endclass

module tb_stereo_dynamic_range_compressor;
    import sdrc_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] in_left;
    logic signed [23:0] in_right;
    logic signed [23:0] key_left;
    logic signed [23:0] key_right;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_data;

    comp_scoreboard sb;
    int             send_idle;
    int             recv_stall;

    stereo_dynamic_range_compressor u_top (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_frame(out_left, out_right);
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_cfg(logic [3:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    task automatic send_frame(logic signed [23:0] il, ir, kl, kr);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_left   <= il;
        in_right  <= ir;
        key_left  <= kl;
        key_right <= kr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_frame(il, ir, kl, kr);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.want_left.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(signed'($urandom_range(64)) - 32);
            3: return $urandom >> $urandom_range(23, 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(bit extreme);
        write_cfg(REG_THRESHOLD, extreme ? ($urandom_range(1) ? 32'h4000 : 32'h3FFF)
                                         : -$urandom_range(15360));
        write_cfg(REG_DOWN_SLOPE, extreme ? 32'hFFFF : $urandom_range(65535));
        write_cfg(REG_DOWN_COEFS, $urandom);
        write_cfg(REG_WET_GAIN, extreme ? 32'hFFFFF : $urandom_range(20000, 300000));
        write_cfg(REG_DRY_GAIN, extreme ? 32'h1FFFF : $urandom_range(65536));
        write_cfg(REG_UP_THRESH, extreme ? 32'h7FFF : -$urandom_range(25599));
        write_cfg(REG_UP_SLOPE, $urandom_range(3) == 0 ? 0 : $urandom_range(65535));
        write_cfg(REG_UP_COEFS, $urandom);
        write_cfg(4'd9, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_left = '0;
        in_right = '0;
        key_left = '0;
        key_right = '0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, silent key, extremes, upward branch
        send_frame(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
        send_frame(24'sh123456, -24'sh123456, 0, 0);
        send_frame(24'sh800000, 24'sh7FFFFF, 1, -1);
        send_frame(24'sh000001, -24'sh1, 24'sh800000, 0);
        drain();
        write_cfg(REG_THRESHOLD, -15360);
        write_cfg(REG_DOWN_SLOPE, 65535);
        write_cfg(REG_DOWN_COEFS, 32'hF000_FF00);
        write_cfg(REG_WET_GAIN, 32'hFFFFF);
        write_cfg(REG_DRY_GAIN, 65536);
        write_cfg(REG_UP_THRESH, 0);
        write_cfg(REG_UP_SLOPE, 65535);
        write_cfg(REG_UP_COEFS, 32'h8000_4000);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 12; i++)
            send_frame(rand_sample(), rand_sample(), i < 3 ? 1 : rand_sample(),
                       i == 4 ? 0 : rand_sample());
        drain();
        write_cfg(REG_UP_THRESH, -25600);
        cfg_valid <= 1'b0;
        send_frame(24'sh400000, 24'sh400000, 24'sh10, 0);
        send_frame(24'sh400000, 24'sh400000, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 67; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 67; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            random_config(ph == 3 || ph == 6);
            for (int i = 0; i < 125; i++)
            begin
                if ($urandom_range(1))
                    send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
                else
                    send_frame(rand_sample(), rand_sample(), in_left, in_right);
            end
            drain();
        end

        if (sb.fails == 0 && sb.want_left.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/sdrc_pkg.sv
rtl/core/sdrc_mul.sv
rtl/core/stereo_dynamic_range_compressor.sv
rtl/core/sdrc_check.sv
tb/tb_stereo_dynamic_range_compressor.sv
